/* rtl/core/restart_backoff_supervisor_macros.svh */
// Assertion macros for the restart backoff supervisor.
`ifndef RESTART_BACKOFF_SUPERVISOR_MACROS_SVH
`define RESTART_BACKOFF_SUPERVISOR_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define RBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbs assertion failed");

// Next-cycle implication, reset-qualified.
`define RBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbs assertion failed");

`endif

/* rtl/core/rbs_pkg.sv */
// Package: types, constants and codes for the restart backoff supervisor.
`timescale 1ns / 1ps
package rbs_pkg;

  localparam int unsigned MAX_FAILURES = 16;
  localparam int unsigned IDX_W        = $clog2(MAX_FAILURES);
  localparam int unsigned CNT_W        = $clog2(MAX_FAILURES + 1);

  localparam logic [15:0] BACKOFF_CAP_MS  = 16'd30000;
  localparam logic [31:0] UPTIME_RESET_MS = 32'd60000;

  // configuration register indexes
  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_BACKOFF = 2'd1;
  localparam logic [1:0] CFG_CAP     = 2'd2;
  localparam logic [1:0] CFG_WINDOW  = 2'd3;

  // restart policies
  localparam logic [1:0] POL_NEVER      = 2'd0;
  localparam logic [1:0] POL_ON_FAILURE = 2'd1;

  localparam logic [1:0] RST_POLICY  = 2'd2;
  localparam logic [15:0] RST_BACKOFF = 16'd500;
  localparam logic [4:0] RST_CAP     = 5'd5;
  localparam logic [31:0] RST_WINDOW  = 32'd60000;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_EXITED  = 2'd1,
    ACT_FAILED  = 2'd2,
    ACT_IGNORED = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_TRIM,
    S_DECIDE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic        launch_failed;
    logic        has_exit_code;
    logic [7:0]  exit_code;
    logic [31:0] exit_time_ms;
    logic [31:0] uptime_ms;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] backoff_ms;
    logic [31:0] restart_count;
    logic [4:0]  failures_in_window;
  } out_word_t;

  // control of the timestamp chain
  typedef struct packed {
    logic shift;  // every cell takes its right neighbour, head drops out
    logic push;   // write the new timestamp at the selected cell
  } chain_ctrl_t;

endpackage

/* rtl/core/rbs_cell.sv */
// One timestamp cell of the failure chain.
`timescale 1ns / 1ps
module rbs_cell
  import rbs_pkg::*;
(
  input  logic        clk_i,
  input  logic        shift_i,
  input  logic        load_i,
  input  logic [31:0] next_i,
  input  logic [31:0] load_data_i,
  output logic [31:0] data_o
);

  logic [31:0] data_q;
  logic [31:0] data_d;

  // load wins over shift: a push into a full chain lands in the tail cell
  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = load_data_i;
    end else if (shift_i) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* rtl/core/rbs_chain.sv */
// Row of timestamp cells holding recent failures, oldest in cell 0.
`timescale 1ns / 1ps
module rbs_chain
  import rbs_pkg::*;
(
  input  logic             clk_i,
  input  chain_ctrl_t      ctrl_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  logic [31:0]      wr_data_i,
  output logic [31:0]      head_o
);

  logic [31:0] data [MAX_FAILURES];

  for (genvar i = 0; i < MAX_FAILURES; i++) begin : g_cell
    logic [31:0] nbr;
    logic        load;

    if (i == MAX_FAILURES - 1) begin : g_tail
      assign nbr = wr_data_i;
    end else begin : g_body
      assign nbr = data[i+1];
    end

    assign load = ctrl_i.push && (wr_idx_i == IDX_W'(i));

    rbs_cell u_cell (
      .clk_i       (clk_i),
      .shift_i     (ctrl_i.shift),
      .load_i      (load),
      .next_i      (nbr),
      .load_data_i (wr_data_i),
      .data_o      (data[i])
    );
  end

  assign head_o = data[0];

endmodule

/* rtl/core/restart_backoff_supervisor.sv */
// Top level: restart supervisor with exponential backoff and failure window.
//
// One input word per finished run of the supervised job (launch failure, exit
// code, exit timestamp, uptime); one result word back per input word (action,
// backoff, restart total, failures in window). Both channels are valid/ready.
// Configuration is a plain write port (enable, index, data), used while idle;
// writing the backoff start also reloads the running backoff.
//
// Sequence: an accepted word passes the push step and then the emit step to
// the output register when supervision stops without recording a failure; when
// a failure is recorded it passes push, trim (one shift per stale timestamp
// dropped, 0..15), decide and emit. The trimming runs one cell shift per cycle
// through the timestamp chain; a new word is accepted only back in idle.
//
// Reset: policy always, backoff 500 ms, cap 5, window 60000 ms, no failures
// held, restart total zero, not terminal. Timestamp cells are not cleared;
// only entries below the fill count are ever read.
//
// A stalled receiver holds the result in the output register; a new word is
// still accepted and worked on, and waits in its final step for the register.
`timescale 1ns / 1ps
`include "restart_backoff_supervisor_macros.svh"
module restart_backoff_supervisor
  import rbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  // input words
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  // result words
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  // configuration registers
  logic [1:0]  policy_q;
  logic [15:0] bo_start_q;
  logic [4:0]  cap_q;
  logic [31:0] window_q;

  // supervision state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [15:0]      backoff_q;
  logic [31:0]      restarts_q;
  logic             term_q;

  // word being worked on and its outcome
  in_word_t    item_q;
  act_e        act_q;
  logic [15:0] bo_out_q;

  // output register
  out_word_t out_q;
  logic      out_valid_q;

  // control from the sequencer
  logic        in_ready;
  logic        do_push;
  logic        do_trim;
  logic        do_decide;
  logic        do_emit;
  chain_ctrl_t chain_ctrl;

  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      head;
  logic [31:0]      age;
  logic             stale;
  logic             chain_full;
  logic             stops_now;
  logic [CNT_W-1:0] cap_eff;
  logic [16:0]      bo_dbl;
  logic [15:0]      bo_next;

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  assign chain_full = (count_q == CNT_W'(MAX_FAILURES));
  assign wr_idx     = chain_full ? IDX_W'(MAX_FAILURES - 1) : count_q[IDX_W-1:0];

  // age of the oldest entry, modulo 2^32
  assign age   = item_q.exit_time_ms - head;
  assign stale = (count_q != '0) && (age > window_q);

  // an event that ends supervision without touching the failure record
  assign stops_now = term_q || item_q.launch_failed || (policy_q == POL_NEVER) ||
                     ((policy_q == POL_ON_FAILURE) && item_q.has_exit_code &&
                      (item_q.exit_code == 8'd0));

  always_comb begin
    if (32'(cap_q) > 32'(MAX_FAILURES)) begin
      cap_eff = CNT_W'(MAX_FAILURES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  assign bo_dbl = {backoff_q, 1'b0};
  always_comb begin
    if (item_q.uptime_ms >= UPTIME_RESET_MS) begin
      bo_next = bo_start_q;
    end else if (bo_dbl < {1'b0, BACKOFF_CAP_MS}) begin
      bo_next = bo_dbl[15:0];
    end else begin
      bo_next = BACKOFF_CAP_MS;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        state_d = stops_now ? S_EMIT : S_TRIM;
      end
      S_TRIM: begin
        if (!stale) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready   = 1'b0;
    do_push    = 1'b0;
    do_trim    = 1'b0;
    do_decide  = 1'b0;
    do_emit    = 1'b0;
    chain_ctrl = '0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_PUSH: begin
        do_push          = 1'b1;
        chain_ctrl.push  = !stops_now;
        chain_ctrl.shift = !stops_now && chain_full;
      end
      S_TRIM: begin
        do_trim          = stale;
        chain_ctrl.shift = stale;
      end
      S_DECIDE: begin
        do_decide = 1'b1;
      end
      S_EMIT: begin
        do_emit = !out_valid_q || out_ready_i;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Timestamp chain
  // ---------------------------------------------------------------------------
  rbs_chain u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (chain_ctrl),
    .wr_idx_i  (wr_idx),
    .wr_data_i (item_q.exit_time_ms),
    .head_o    (head)
  );

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      policy_q    <= RST_POLICY;
      bo_start_q  <= RST_BACKOFF;
      cap_q       <= RST_CAP;
      window_q    <= RST_WINDOW;
      count_q     <= '0;
      backoff_q   <= RST_BACKOFF;
      restarts_q  <= '0;
      term_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY:  policy_q <= cfg_data_i[1:0];
          CFG_BACKOFF: begin
            bo_start_q <= cfg_data_i[15:0];
            backoff_q  <= cfg_data_i[15:0];
          end
          CFG_CAP:     cap_q    <= cfg_data_i[4:0];
          CFG_WINDOW:  window_q <= cfg_data_i;
          default:     policy_q <= policy_q;
        endcase
      end

      if (do_push) begin
        if (stops_now) begin
          if (!term_q) begin
            term_q <= 1'b1;
          end
        end else begin
          restarts_q <= restarts_q + 32'd1;
          if (!chain_full) begin
            count_q <= count_q + CNT_W'(1);
          end
        end
      end

      if (do_trim) begin
        count_q <= count_q - CNT_W'(1);
      end

      if (do_decide) begin
        if (count_q >= cap_eff) begin
          term_q <= 1'b1;
        end else begin
          backoff_q <= bo_next;
        end
      end

      if (do_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      item_q <= in_word_i;
    end

    if (do_push && stops_now) begin
      bo_out_q <= 16'd0;
      if (term_q) begin
        act_q <= ACT_IGNORED;
      end else if (item_q.launch_failed) begin
        act_q <= ACT_FAILED;
      end else begin
        act_q <= ACT_EXITED;
      end
    end

    if (do_decide) begin
      if (count_q >= cap_eff) begin
        act_q    <= ACT_FAILED;
        bo_out_q <= 16'd0;
      end else begin
        act_q    <= ACT_RESTART;
        bo_out_q <= bo_next;
      end
    end

    if (do_emit) begin
      out_q.action             <= act_q;
      out_q.backoff_ms         <= bo_out_q;
      out_q.restart_count      <= restarts_q;
      out_q.failures_in_window <= 5'(count_q);
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RBS_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_FAILURES))
  `RBS_ASSERT_NEXT(a_term_sticky, clk_i, rst_ni, term_q, term_q)
  `RBS_ASSERT_NEXT(a_trim_drops_one, clk_i, rst_ni, do_trim,
                   count_q == $past(count_q) - CNT_W'(1))
  `RBS_ASSERT_NEXT(a_total_only_on_push, clk_i, rst_ni, state_q != S_PUSH,
                   $stable(restarts_q))

endmodule
